@@ hw/rtl/dft_pkg.sv @@
// ----------------------------------------------------------------------------
// dft_pkg
// Types and constants shared by the delimited field tokenizer modules.
// ----------------------------------------------------------------------------
package dft_pkg;

    localparam int CHAR_W   = 8;
    localparam int MSGLEN_W = 13;
    localparam int NFLD_W   = 7;
    localparam int FLEN_W   = 11;
    localparam int KIND_W   = 2;
    localparam int FIDX_W   = 6;
    localparam int POS_W    = 10;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TDATA_W  = 40;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // line status
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LONG = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SEPARATOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MSG   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FLDS  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FLEN  = 2'd3;

    localparam logic [CHAR_W-1:0]   SEP_RESET    = 8'd124;
    localparam logic [MSGLEN_W-1:0] MSG_RESET    = 13'd1024;
    localparam logic [NFLD_W-1:0]   FIELDS_RESET = 7'd16;
    localparam logic [FLEN_W-1:0]   FLEN_RESET   = 11'd64;

    localparam logic [CHAR_W-1:0]   CHAR_EOL   = 8'h00;
    localparam logic [CHAR_W-1:0]   CTRL_LIMIT = 8'h20;
    localparam logic [CHAR_W-1:0]   LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0]   LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0]   CASE_DELTA = 8'h20;
    localparam logic [MSGLEN_W-1:0] LEN_MAX    = 13'd8191;
    localparam logic [NFLD_W-1:0]   FIELD_MAX  = 7'd127;
    localparam logic [FLEN_W-1:0]   POS_MAX    = 11'd2047;

    typedef struct packed {
        logic [CHAR_W-1:0]   separator;
        logic [MSGLEN_W-1:0] max_msg_len;
        logic [NFLD_W-1:0]   max_fields;
        logic [FLEN_W-1:0]   max_field_len;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] out_char;
        logic [FIDX_W-1:0] field_index;
        logic [POS_W-1:0]  char_position;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  field_count;
    } t_result;

endpackage

@@ hw/rtl/dft_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dft_cfg_regs
// Configuration registers: separator, message, field count and field limits.
// ----------------------------------------------------------------------------
module dft_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dft_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [dft_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output dft_pkg::t_cfg                   o_cfg
);
    import dft_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator     <= SEP_RESET;
            r_cfg.max_msg_len   <= MSG_RESET;
            r_cfg.max_fields    <= FIELDS_RESET;
            r_cfg.max_field_len <= FLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SEPARATOR: r_cfg.separator     <= i_cfg_wdata[CHAR_W-1:0];
                CFG_MAX_MSG:   r_cfg.max_msg_len   <= i_cfg_wdata[MSGLEN_W-1:0];
                CFG_MAX_FLDS:  r_cfg.max_fields    <= i_cfg_wdata[NFLD_W-1:0];
                CFG_MAX_FLEN:  r_cfg.max_field_len <= i_cfg_wdata[FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/dft_step.sv @@
// ----------------------------------------------------------------------------
// dft_step
// Line state counters and the per-character result logic.
// ----------------------------------------------------------------------------
module dft_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [dft_pkg::CHAR_W-1:0]  i_char,
    input  dft_pkg::t_cfg               i_cfg,
    output dft_pkg::t_result            o_res
);
    import dft_pkg::*;

    logic [MSGLEN_W-1:0] r_line_len, n_line_len;
    logic [NFLD_W-1:0]   r_cur_field, n_cur_field;
    logic [FLEN_W-1:0]   r_field_pos, n_field_pos;
    logic                r_err, n_err;

    logic                empty_first;
    logic [MSGLEN_W-1:0] len_inc;
    logic [NFLD_W:0]     field_plus;
    logic [FLEN_W:0]     pos_plus;
    logic                is_lower;
    logic [STAT_W-1:0]   stat;

    assign empty_first = (r_cur_field == '0) && (r_field_pos == '0);
    assign len_inc     = (r_line_len < LEN_MAX) ? r_line_len + 1'b1 : LEN_MAX;
    assign field_plus  = {1'b0, r_cur_field} + 1'b1;
    assign pos_plus    = {1'b0, r_field_pos} + 1'b1;
    assign is_lower    = (i_char >= LOWER_A) && (i_char <= LOWER_Z);

    always_comb begin
        n_line_len  = r_line_len;
        n_cur_field = r_cur_field;
        n_field_pos = r_field_pos;
        n_err       = r_err;
        o_res       = '0;
        o_res.field_index   = r_cur_field[FIDX_W-1:0];
        o_res.char_position = r_field_pos[POS_W-1:0];

        if (i_char == CHAR_EOL) begin
            o_res.kind = KIND_END;
            n_err      = r_err | empty_first;
        end else if (i_char == i_cfg.separator) begin
            o_res.kind  = KIND_SEP;
            n_err       = r_err | empty_first
                          | (field_plus >= {1'b0, i_cfg.max_fields});
            n_line_len  = len_inc;
            n_cur_field = (r_cur_field < FIELD_MAX) ? field_plus[NFLD_W-1:0] : FIELD_MAX;
            n_field_pos = '0;
        end else begin
            o_res.kind     = KIND_CHAR;
            o_res.out_char = (r_cur_field == '0 && is_lower) ? i_char - CASE_DELTA : i_char;
            n_err          = r_err | (i_char < CTRL_LIMIT)
                             | (pos_plus >= {1'b0, i_cfg.max_field_len});
            n_line_len     = len_inc;
            n_field_pos    = (r_field_pos < POS_MAX) ? pos_plus[FLEN_W-1:0] : POS_MAX;
        end

        // too long wins over a bad request
        if (n_line_len >= i_cfg.max_msg_len) begin
            stat = ST_LONG;
        end else if (n_err) begin
            stat = ST_BAD;
        end else begin
            stat = ST_OK;
        end
        o_res.status = stat;

        if (o_res.kind == KIND_END) begin
            if (stat == ST_OK) begin
                o_res.field_count = field_plus[CNT_W-1:0];
            end
            n_line_len  = '0;
            n_cur_field = '0;
            n_field_pos = '0;
            n_err       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len  <= '0;
            r_cur_field <= '0;
            r_field_pos <= '0;
            r_err       <= 1'b0;
        end else if (i_adv) begin
            r_line_len  <= n_line_len;
            r_cur_field <= n_cur_field;
            r_field_pos <= n_field_pos;
            r_err       <= n_err;
        end
    end

endmodule

@@ hw/rtl/delimited_field_tokenizer.sv @@
// ----------------------------------------------------------------------------
// delimited_field_tokenizer
// Splits a character stream into separator-delimited fields, one result
// beat per character.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one character per beat in tdata; code 0 ends the line.
//   Master stream: one result beat per input beat. tuser holds the result
//   kind (character, field end at separator, line end); tdata holds the
//   character, field index, position, status and, at an ok line end, the count.
//   Config port: write enable, register index and data; write only while
//   no beat is in flight.
//   An input beat is held in the input register, then the counter update and
//   result logic feed the output register when the result can advance.
//   Throughput is one character per cycle while the receiver takes results:
//   the line counters update as each beat advances, so a new beat is taken
//   every cycle. When the receiver stalls, the result is held; tready stays
//   high only while the input register is empty.
//   Reset clears both valid flags and the line state and loads default limits.
// ----------------------------------------------------------------------------
module delimited_field_tokenizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [dft_pkg::CHAR_W-1:0]    i_s_axis_tdata,  // [7:0] char_code
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [7:0] out_char, [13:8] field_index, [23:14] char_position,
    // [25:24] status, [32:26] field_count, [39:33] zero
    output logic [dft_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic [dft_pkg::KIND_W-1:0]    o_m_axis_tuser,  // [1:0] result_kind
    input  logic                          i_cfg_we,
    input  logic [dft_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dft_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dft_pkg::*;

    t_cfg              cfg;
    t_result           res;
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_valid;
    t_result           r_out;
    logic              adv;
    logic              in_ready;

    assign adv      = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign in_ready = !r_in_valid || adv;

    dft_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dft_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_char  (r_in_char),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {{(TDATA_W - CNT_W - STAT_W - POS_W - FIDX_W - CHAR_W){1'b0}},
                              r_out.field_count, r_out.status, r_out.char_position,
                              r_out.field_index, r_out.out_char};

endmodule

@@ hw/rtl/dft_checker.sv @@
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks on the tokenizer result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dft_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [dft_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    input logic [dft_pkg::KIND_W-1:0]      o_m_axis_tuser
);
    import dft_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // a count only at an ok line end
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[32:26] != '0) |->
            (o_m_axis_tuser == KIND_END) && (o_m_axis_tdata[25:24] == ST_OK))
        else $error("field count outside an ok line end");

    // separator and line end carry no character
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser != KIND_CHAR) |->
            (o_m_axis_tdata[7:0] == '0))
        else $error("character on a non-character beat");

    // the result stream is not valid straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    // a line end with status ok reports at least one field, unless its field index reads 63
    a_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_END) && (o_m_axis_tdata[25:24] == ST_OK)
            && (o_m_axis_tdata[13:8] != 6'd63) |-> (o_m_axis_tdata[32:26] != '0))
        else $error("ok line end without a field count");

endmodule

bind delimited_field_tokenizer dft_checker u_dft_checker (.*);

@@ test/delimited_field_tokenizer_checker.sv @@
// ----------------------------------------------------------------------------
// delimited_field_tokenizer_checker
// Watches the character stream, the result stream and the register port of
// the tokenizer. It keeps its own copy of the limits and the line state,
// predicts one result beat per character beat and compares each result beat,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module delimited_field_tokenizer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [dft_pkg::CHAR_W-1:0]     i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [dft_pkg::TDATA_W-1:0]    i_m_tdata,
    input  logic [dft_pkg::KIND_W-1:0]     i_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [dft_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dft_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_beats,
    output int                             o_lines,
    output int                             o_flagged_lines
);
    import dft_pkg::*;

    localparam int FIDX_LSB = CHAR_W;
    localparam int POS_LSB  = FIDX_LSB + FIDX_W;
    localparam int STAT_LSB = POS_LSB + POS_W;
    localparam int CNT_LSB  = STAT_LSB + STAT_W;
    localparam int PAD_LSB  = CNT_LSB + CNT_W;

    logic [CHAR_W-1:0]   lim_sep;
    logic [MSGLEN_W-1:0] lim_msg;
    logic [NFLD_W-1:0]   lim_fields;
    logic [FLEN_W-1:0]   lim_flen;

    logic [MSGLEN_W-1:0] line_len;
    logic [NFLD_W-1:0]   fld_no;
    logic [FLEN_W-1:0]   fld_pos;
    logic                line_bad;

    t_result expected_results[$];

    int mismatches    = 0;
    int pending_count = 0;
    int beats_checked = 0;
    int lines_checked = 0;
    int lines_flagged = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = pending_count;
    assign o_beats         = beats_checked;
    assign o_lines         = lines_checked;
    assign o_flagged_lines = lines_flagged;

    // too long wins over a bad request
    function automatic logic [STAT_W-1:0] line_verdict();
        if (line_len >= lim_msg) return ST_LONG;
        return line_bad ? ST_BAD : ST_OK;
    endfunction

    function automatic t_result tokenize_char(input logic [CHAR_W-1:0] c);
        t_result r;
        r = '0;
        r.field_index   = fld_no[FIDX_W-1:0];
        r.char_position = fld_pos[POS_W-1:0];
        if (c == CHAR_EOL) begin
            r.kind = KIND_END;
            if (fld_no == '0 && fld_pos == '0) line_bad = 1'b1;
            r.status = line_verdict();
            if (r.status == ST_OK) r.field_count = fld_no + 1'b1;
            line_len = '0;
            fld_no   = '0;
            fld_pos  = '0;
            line_bad = 1'b0;
        end else if (c == lim_sep) begin
            r.kind = KIND_SEP;
            if (fld_no == '0 && fld_pos == '0) line_bad = 1'b1;
            if ({1'b0, fld_no} + 1'b1 >= {1'b0, lim_fields}) line_bad = 1'b1;
            if (line_len != LEN_MAX) line_len = line_len + 1'b1;
            if (fld_no != FIELD_MAX) fld_no = fld_no + 1'b1;
            fld_pos = '0;
            r.status = line_verdict();
        end else begin
            r.kind     = KIND_CHAR;
            r.out_char = c;
            if (fld_no == '0 && c >= LOWER_A && c <= LOWER_Z) r.out_char = c - CASE_DELTA;
            if (c < CTRL_LIMIT) line_bad = 1'b1;
            if ({1'b0, fld_pos} + 1'b1 >= {1'b0, lim_flen}) line_bad = 1'b1;
            if (line_len != LEN_MAX) line_len = line_len + 1'b1;
            if (fld_pos != POS_MAX) fld_pos = fld_pos + 1'b1;
            r.status = line_verdict();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        mismatches++;
        $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got_v, want_v);
    endtask

    task automatic compare_field(input string what, input int got_v, input int want_v);
        if (got_v != want_v) report_mismatch(what, got_v, want_v);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            lim_sep    = SEP_RESET;
            lim_msg    = MSG_RESET;
            lim_fields = FIELDS_RESET;
            lim_flen   = FLEN_RESET;
            line_len   = '0;
            fld_no     = '0;
            fld_pos    = '0;
            line_bad   = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SEPARATOR: lim_sep    = i_cfg_wdata[CHAR_W-1:0];
                    CFG_MAX_MSG:   lim_msg    = i_cfg_wdata[MSGLEN_W-1:0];
                    CFG_MAX_FLDS:  lim_fields = i_cfg_wdata[NFLD_W-1:0];
                    CFG_MAX_FLEN:  lim_flen   = i_cfg_wdata[FLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) expected_results.push_back(tokenize_char(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                beats_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat, kind", int'(i_m_tuser), 0);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", int'(i_m_tuser), int'(want.kind));
                    compare_field("out_char", int'(i_m_tdata[CHAR_W-1:0]), int'(want.out_char));
                    compare_field("field_index", int'(i_m_tdata[FIDX_LSB +: FIDX_W]),
                                  int'(want.field_index));
                    compare_field("char_position", int'(i_m_tdata[POS_LSB +: POS_W]),
                                  int'(want.char_position));
                    compare_field("status", int'(i_m_tdata[STAT_LSB +: STAT_W]),
                                  int'(want.status));
                    compare_field("field_count", int'(i_m_tdata[CNT_LSB +: CNT_W]),
                                  int'(want.field_count));
                    compare_field("tdata padding", int'(i_m_tdata[TDATA_W-1:PAD_LSB]), 0);
                    if (want.kind == KIND_END) begin
                        lines_checked++;
                        if (want.status != ST_OK) lines_flagged++;
                    end
                end
            end
        end
        pending_count <= expected_results.size();
    end

endmodule

@@ test/delimited_field_tokenizer_test.sv @@
// ----------------------------------------------------------------------------
// delimited_field_tokenizer_test
// Drives character lines into the tokenizer under a series of limit settings:
// a directed set of corner lines, one long line at the largest limits,
// random phases of mostly well-formed lines with some broken ones and noise,
// and settings outside the documented ranges. Both streams idle at random.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module delimited_field_tokenizer_test;
    import dft_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 600;
    localparam int DRAIN_CYCLES = 4;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_SEPARATOR;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  calm      = 1'b0;

    int mismatch_count;
    int pending;
    int beats_seen;
    int lines_seen;
    int lines_flagged;

    int cycle_count   = 0;
    int chars_sent    = 0;
    int settings_used = 1;

    logic [CHAR_W-1:0] cur_sep = SEP_RESET;
    int                cur_flds = 16;
    int                cur_flen = 64;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    delimited_field_tokenizer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    delimited_field_tokenizer_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatches    (mismatch_count),
        .o_pending       (pending),
        .o_beats         (beats_seen),
        .o_lines         (lines_seen),
        .o_flagged_lines (lines_flagged)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        m_tready    <= calm || ($urandom_range(99) >= 8);
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timed out after %0d cycles", cycle_count);
        $display("delimited_field_tokenizer regression: fail");
        $finish;
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_char(CHAR_W'(s[i]));
    endtask

    // the checker's pending count is registered, hence the first wait
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [CHAR_W-1:0] sep, input logic [MSGLEN_W-1:0] msg,
                              input logic [NFLD_W-1:0] flds, input logic [FLEN_W-1:0] flen);
        hold_until_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SEPARATOR;
        cfg_wdata <= CFG_DATA_W'(sep);
        @(posedge clk);
        cfg_addr  <= CFG_MAX_MSG;
        cfg_wdata <= msg;
        @(posedge clk);
        cfg_addr  <= CFG_MAX_FLDS;
        cfg_wdata <= CFG_DATA_W'(flds);
        @(posedge clk);
        cfg_addr  <= CFG_MAX_FLEN;
        cfg_wdata <= CFG_DATA_W'(flen);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_sep  = sep;
        cur_flds = int'(flds);
        cur_flen = int'(flen);
        settings_used++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_text_char(input bit lead);
        logic [CHAR_W-1:0] c;
        do begin
            if (lead && $urandom_range(3) == 0) c = CHAR_W'($urandom_range(LOWER_A, LOWER_Z));
            else c = CHAR_W'($urandom_range(CTRL_LIMIT, 8'hFF));
        end while (c == cur_sep);
        return c;
    endfunction

    // mostly well-formed lines; some broken by length, field count, an empty
    // first field or a control code; a tenth are plain noise
    task automatic send_random_line();
        int style;
        int nflds;
        int lim;
        int fl;
        logic [CHAR_W-1:0] c;
        style = $urandom_range(99);
        if (style < 10) begin
            repeat ($urandom_range(0, 16)) begin
                if ($urandom_range(4) == 0) c = cur_sep;
                else c = CHAR_W'($urandom_range(1, 255));
                send_char(c);
            end
        end else begin
            lim = (cur_flds > 1) ? ((cur_flds - 1 < 6) ? cur_flds - 1 : 6) : 1;
            nflds = $urandom_range(1, lim);
            if ($urandom_range(19) == 0) nflds = cur_flds + $urandom_range(0, 2);
            lim = (cur_flen > 1) ? ((cur_flen - 1 < 10) ? cur_flen - 1 : 10) : 1;
            for (int f = 0; f < nflds; f++) begin
                fl = $urandom_range((f == 0) ? 1 : 0, lim);
                if (cur_flen >= 1 && cur_flen <= 80 && $urandom_range(24) == 0)
                    fl = cur_flen - 1 + $urandom_range(0, 1);
                if (f == 0 && $urandom_range(24) == 0) fl = 0;
                if (f > 0) send_char(cur_sep);
                for (int i = 0; i < fl; i++) begin
                    c = pick_text_char(f == 0);
                    if ($urandom_range(39) == 0) c = CHAR_W'($urandom_range(1, 31));
                    send_char(c);
                end
            end
        end
        send_char(CHAR_EOL);
    endtask

    initial begin : stimulus
        int base;
        logic [CHAR_W-1:0]   sep_pick;
        logic [MSGLEN_W-1:0] msg_pick;
        logic [NFLD_W-1:0]   flds_pick;
        logic [FLEN_W-1:0]   flen_pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default limits: empty line, case folding edges, empty first field,
        // control codes and the extreme codes
        send_char(CHAR_EOL);
        send_str("az");
        send_char(8'h60);
        send_char(8'h7B);
        send_str("|az");
        hold_until_drained();
        send_char(CHAR_EOL);
        send_str("|x");
        send_char(CHAR_EOL);
        send_str("A");
        send_char(8'h1F);
        send_char(8'hFF);
        send_char(8'h20);
        send_char(CHAR_EOL);
        send_str("q");
        send_char(8'h01);
        send_char(CHAR_EOL);

        // smallest limits: too long over bad request, too many fields
        set_limits(8'h7C, 13'd2, 7'd1, 11'd2);
        send_str("a");
        send_char(CHAR_EOL);
        send_str("ab");
        send_char(CHAR_EOL);
        send_str("a|b");
        send_char(CHAR_EOL);

        // largest limits; one line with enough fields to pass the field limit,
        // wrap the field index and saturate the field counter, no idling
        set_limits(8'hFF, 13'd4096, 7'd64, 11'd1024);
        calm <= 1'b1;
        repeat (20) send_char(8'h78);
        repeat (130) begin
            send_char(8'hFF);
            send_char(8'h6D);
        end
        repeat (20) send_char(8'h71);
        send_char(CHAR_EOL);
        hold_until_drained();
        calm <= 1'b0;
        repeat (5) send_random_line();

        base = chars_sent;
        while (chars_sent - base < RANDOM_CHARS) begin
            case ($urandom_range(5))
                0: sep_pick = 8'h7C;
                1: sep_pick = 8'h2C;
                2: sep_pick = 8'h09;
                3: sep_pick = 8'h01;
                4: sep_pick = 8'hFF;
                default: sep_pick = CHAR_W'($urandom_range(1, 255));
            endcase
            msg_pick  = $urandom_range(1) ? MSGLEN_W'($urandom_range(2, 40))
                                          : MSGLEN_W'($urandom_range(41, 4096));
            flds_pick = $urandom_range(1) ? NFLD_W'($urandom_range(1, 6))
                                          : NFLD_W'($urandom_range(7, 64));
            flen_pick = $urandom_range(1) ? FLEN_W'($urandom_range(2, 10))
                                          : FLEN_W'($urandom_range(11, 1024));
            set_limits(sep_pick, msg_pick, flds_pick, flen_pick);
            repeat ($urandom_range(5, 12)) send_random_line();
        end

        // settings outside the documented ranges, a zero separator among them
        set_limits(8'h00, 13'h1FFF, 7'h7F, 11'h7FF);
        repeat (4) send_random_line();
        set_limits(8'h2F, '0, '0, '0);
        repeat (3) send_random_line();

        hold_until_drained();
        $display("ran %0d characters as %0d lines under %0d limit settings",
                 chars_sent, lines_seen, settings_used);
        $display("compared %0d result beats; %0d lines ended bad or too long",
                 beats_seen, lines_flagged);
        if (mismatch_count == 0)
            $display("delimited_field_tokenizer regression: pass");
        else
            $display("delimited_field_tokenizer regression: fail");
        $finish;
    end

endmodule
